>>> hdl/power_down_sequence_supervisor_top_defines.svh
// assertion macros for the power-down sequence supervisor checker
`ifndef POWER_DOWN_SEQUENCE_SUPERVISOR_TOP_DEFINES_SVH
`define POWER_DOWN_SEQUENCE_SUPERVISOR_TOP_DEFINES_SVH

// same-cycle implication, checked outside reset
`define PDSS_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// next-cycle implication, checked outside reset
`define PDSS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

>>> hdl/pdss_pkg.sv
// shared types, codes and helpers of the power-down sequence supervisor
package pdss_pkg;

    localparam int TIME_W     = 63;
    localparam int ELAPSED_W  = 16;
    localparam int MASK_W     = 8;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;
    localparam int CMD_W      = 3;
    localparam int UIDX_W     = 3;
    localparam int STAT_W     = 2;

    typedef enum logic [2:0] {
        MODE_STARTUP         = 3'd0,
        MODE_STARTUP_TIMEOUT = 3'd1,
        MODE_RUNNING         = 3'd2,
        MODE_PREPARING       = 3'd3,
        MODE_PREPARE_TIMEOUT = 3'd4,
        MODE_READY           = 3'd5
    } t_seq_mode;

    // item commands
    localparam logic [CMD_W-1:0] CMD_TICK       = 3'd0;
    localparam logic [CMD_W-1:0] CMD_STATUS     = 3'd1;
    localparam logic [CMD_W-1:0] CMD_SHUTDOWN   = 3'd2;
    localparam logic [CMD_W-1:0] CMD_FORCED     = 3'd3;
    localparam logic [CMD_W-1:0] CMD_EXEC_REPLY = 3'd4;

    // unit status codes
    localparam logic [STAT_W-1:0] ST_UNKNOWN = 2'd0;
    localparam logic [STAT_W-1:0] ST_RUNNING = 2'd1;
    localparam logic [STAT_W-1:0] ST_READY   = 2'd2;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_STARTUP_TO = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PREPARE_TO = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PRESENT    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SKIP       = 3'd3;

    localparam logic [ELAPSED_W-1:0] STARTUP_TO_RST = 16'd300;
    localparam logic [ELAPSED_W-1:0] PREPARE_TO_RST = 16'd60;

    typedef struct packed {
        logic load;
        logic step;
        logic commit;
    } t_dp_cmd;

    typedef struct packed {
        logic sweep_last;
    } t_dp_sts;

    function automatic logic [ELAPSED_W-1:0] sat_inc(input logic [ELAPSED_W-1:0] val);
        sat_inc = (val == '1) ? val : val + 1'b1;
    endfunction

endpackage

>>> hdl/pdss_ctrl.sv
// sequencing controller: accept, unit sweep, commit, result handoff
module pdss_ctrl import pdss_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    output logic    o_in_ready,
    output logic    o_out_valid,
    input  logic    i_out_ready,
    output t_dp_cmd o_dp_cmd,
    input  t_dp_sts i_dp_sts
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_SWEEP,
        S_COMMIT,
        S_OUT
    } t_ctrl_state;

    t_ctrl_state r_state;
    logic        r_in_ready;
    logic        r_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_in_ready  <= 1'b1;
            r_out_valid <= 1'b0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (i_in_valid && r_in_ready) begin
                        r_state    <= S_SWEEP;
                        r_in_ready <= 1'b0;
                    end
                end
                S_SWEEP: begin
                    if (i_dp_sts.sweep_last) begin
                        r_state <= S_COMMIT;
                    end
                end
                S_COMMIT: begin
                    r_state     <= S_OUT;
                    r_out_valid <= 1'b1;
                end
                S_OUT: begin
                    if (i_out_ready) begin
                        r_state     <= S_IDLE;
                        r_out_valid <= 1'b0;
                        r_in_ready  <= 1'b1;
                    end
                end
                default: begin
                    r_state     <= S_IDLE;
                    r_in_ready  <= 1'b1;
                    r_out_valid <= 1'b0;
                end
            endcase
        end
    end

    // no item is taken while reset is held
    assign o_in_ready  = r_in_ready && i_rst_n;
    assign o_out_valid = r_out_valid;

    assign o_dp_cmd.load   = (r_state == S_IDLE) && i_in_valid && r_in_ready;
    assign o_dp_cmd.step   = (r_state == S_SWEEP);
    assign o_dp_cmd.commit = (r_state == S_COMMIT);

endmodule

>>> hdl/pdss_dp.sv
// datapath: config registers, unit tables, sweep accumulators, sequence state
module pdss_dp import pdss_pkg::*; #(
    parameter int NUM_SLOTS = 8
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_valid,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic [CMD_W-1:0]      i_cmd,
    input  logic [UIDX_W-1:0]     i_unit_index,
    input  logic [STAT_W-1:0]     i_unit_status,
    input  logic [TIME_W-1:0]     i_reported_off_time,
    input  logic [TIME_W-1:0]     i_current_time,
    input  t_dp_cmd               i_dp_cmd,
    output t_dp_sts               o_dp_sts,
    output logic [2:0]            o_mode,
    output logic [TIME_W-1:0]     o_final_off_time,
    output logic                  o_prepare_request,
    output logic                  o_execute_request,
    output logic                  o_request_accepted
);

    localparam int IDX_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
    localparam logic [IDX_W-1:0]  LAST_IDX   = IDX_W'(NUM_SLOTS - 1);
    localparam logic [UIDX_W:0]   SLOT_LIMIT = (UIDX_W + 1)'(NUM_SLOTS);

    // configuration
    logic [ELAPSED_W-1:0] r_startup_to;
    logic [ELAPSED_W-1:0] r_prepare_to;
    logic [MASK_W-1:0]    r_present_mask;
    logic [MASK_W-1:0]    r_skip_mask;

    // sequence state
    t_seq_mode            r_mode,      n_mode;
    logic [ELAPSED_W-1:0] r_elapsed,   n_elapsed;
    logic                 r_forced,    n_forced;
    logic                 r_exec_flag, n_exec_flag;
    logic [TIME_W-1:0]    r_latest,    n_latest;
    logic                 r_prep_req,  n_prep_req;
    logic                 r_exec_req,  n_exec_req;
    logic                 r_acc,       n_acc;

    // unit tables
    logic [STAT_W-1:0]    r_status_tab [NUM_SLOTS];
    logic [TIME_W-1:0]    r_off_tab    [NUM_SLOTS];

    // captured item
    logic [CMD_W-1:0]     r_cmd;
    logic [UIDX_W-1:0]    r_unit_index;
    logic [STAT_W-1:0]    r_unit_status;
    logic [TIME_W-1:0]    r_rep;
    logic [TIME_W-1:0]    r_now;

    // sweep
    logic [IDX_W-1:0]     r_idx;
    logic                 r_all_run;
    logic                 r_all_rdy;
    logic [TIME_W-1:0]    r_best;

    logic                 ent_present;
    logic                 ent_skip;
    logic [STAT_W-1:0]    ent_status;
    logic [TIME_W-1:0]    ent_off;
    logic                 ent_counts;
    logic [ELAPSED_W-1:0] elapsed_inc;
    logic                 unit_in_range;
    logic [IDX_W-1:0]     unit_slot;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_startup_to   <= STARTUP_TO_RST;
            r_prepare_to   <= PREPARE_TO_RST;
            r_present_mask <= '0;
            r_skip_mask    <= '0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_STARTUP_TO: r_startup_to   <= i_cfg_data;
                CFG_PREPARE_TO: r_prepare_to   <= i_cfg_data;
                CFG_PRESENT:    r_present_mask <= i_cfg_data[MASK_W-1:0];
                CFG_SKIP:       r_skip_mask    <= i_cfg_data[MASK_W-1:0];
                default: ;
            endcase
        end
    end

    // one table entry per sweep cycle
    assign ent_present = r_present_mask[r_idx];
    assign ent_skip    = r_skip_mask[r_idx];
    assign ent_status  = r_status_tab[r_idx];
    assign ent_off     = r_off_tab[r_idx];
    assign ent_counts  = ent_present && !ent_skip;

    assign o_dp_sts.sweep_last = i_dp_cmd.step && (r_idx == LAST_IDX);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx <= '0;
        end else if (i_dp_cmd.load) begin
            r_idx <= '0;
        end else if (i_dp_cmd.step) begin
            r_idx <= (r_idx == LAST_IDX) ? '0 : IDX_W'(r_idx + 1'b1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_dp_cmd.load) begin
            r_cmd         <= i_cmd;
            r_unit_index  <= i_unit_index;
            r_unit_status <= i_unit_status;
            r_rep         <= i_reported_off_time;
            r_now         <= i_current_time;
            r_all_run     <= 1'b1;
            r_all_rdy     <= 1'b1;
            r_best        <= i_current_time;
        end else if (i_dp_cmd.step) begin
            if (ent_present && ent_status != ST_RUNNING) begin
                r_all_run <= 1'b0;
            end
            if (ent_counts && ent_status != ST_READY) begin
                r_all_rdy <= 1'b0;
            end
            if (ent_counts && ent_off > r_best) begin
                r_best <= ent_off;
            end
        end
    end

    assign unit_in_range = {1'b0, r_unit_index} < SLOT_LIMIT;
    assign unit_slot     = r_unit_index[IDX_W-1:0];

    // status table resets to unknown, time table to zero
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < NUM_SLOTS; k++) begin
                r_status_tab[k] <= ST_UNKNOWN;
                r_off_tab[k]    <= '0;
            end
        end else if (i_dp_cmd.commit && r_cmd == CMD_STATUS && unit_in_range) begin
            r_status_tab[unit_slot] <= r_unit_status;
            r_off_tab[unit_slot]    <= r_rep;
        end
    end

    assign elapsed_inc = sat_inc(r_elapsed);

    always_comb begin
        n_mode      = r_mode;
        n_elapsed   = r_elapsed;
        n_forced    = r_forced;
        n_exec_flag = r_exec_flag;
        n_latest    = r_latest;
        n_prep_req  = r_prep_req;
        n_exec_req  = r_exec_req;
        n_acc       = r_acc;
        if (i_dp_cmd.commit) begin
            n_prep_req = 1'b0;
            n_exec_req = 1'b0;
            n_acc      = 1'b0;
            case (r_cmd)
                CMD_TICK: begin
                    n_elapsed = elapsed_inc;
                    case (r_mode)
                        MODE_STARTUP, MODE_STARTUP_TIMEOUT: begin
                            if (r_all_run) begin
                                n_mode    = MODE_RUNNING;
                                n_elapsed = '0;
                            end else if (elapsed_inc > r_startup_to) begin
                                n_mode = MODE_STARTUP_TIMEOUT;
                            end
                        end
                        MODE_PREPARING, MODE_PREPARE_TIMEOUT: begin
                            if (r_forced || r_all_rdy) begin
                                n_latest  = r_best;
                                n_mode    = MODE_READY;
                                n_elapsed = '0;
                            end else if (elapsed_inc > r_prepare_to) begin
                                n_mode      = MODE_PREPARE_TIMEOUT;
                                n_exec_flag = 1'b0;
                            end
                        end
                        MODE_READY: begin
                            if (!r_exec_flag) begin
                                n_latest    = r_now;
                                n_exec_flag = 1'b1;
                                n_exec_req  = 1'b1;
                            end
                        end
                        default: ;
                    endcase
                end
                CMD_SHUTDOWN, CMD_FORCED: begin
                    n_mode     = MODE_PREPARING;
                    n_elapsed  = '0;
                    n_prep_req = 1'b1;
                    n_acc      = 1'b1;
                    if (r_cmd == CMD_FORCED) begin
                        n_forced = 1'b1;
                    end
                end
                CMD_EXEC_REPLY: begin
                    if (r_exec_flag && unit_in_range && r_present_mask[r_unit_index]
                        && !r_skip_mask[r_unit_index] && r_rep > r_latest) begin
                        n_latest = r_rep;
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode      <= MODE_STARTUP;
            r_elapsed   <= '0;
            r_forced    <= 1'b0;
            r_exec_flag <= 1'b0;
            r_latest    <= '0;
            r_prep_req  <= 1'b0;
            r_exec_req  <= 1'b0;
            r_acc       <= 1'b0;
        end else begin
            r_mode      <= n_mode;
            r_elapsed   <= n_elapsed;
            r_forced    <= n_forced;
            r_exec_flag <= n_exec_flag;
            r_latest    <= n_latest;
            r_prep_req  <= n_prep_req;
            r_exec_req  <= n_exec_req;
            r_acc       <= n_acc;
        end
    end

    assign o_mode             = r_mode;
    assign o_final_off_time   = r_latest;
    assign o_prepare_request  = r_prep_req;
    assign o_execute_request  = r_exec_req;
    assign o_request_accepted = r_acc;

endmodule

>>> hdl/power_down_sequence_supervisor_top.sv
// top level of the power-down sequence supervisor
// after an item is taken, the sweep walks N = min(MAX_UNITS, 8) unit slots, then commits
// and holds the result; a new item is taken only once the result has been taken
// the unit sweep reads one table entry per cycle through one compare unit
// reset: synchronous, active low; registers return to their defaults, mode is start-up,
// all unit states unknown; no clearing pass, the block takes items right after reset
module power_down_sequence_supervisor_top import pdss_pkg::*; #(
    parameter int MAX_UNITS = 8
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // configuration write channel, always ready outside reset
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    // item input channel
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  logic [CMD_W-1:0]      i_cmd,
    input  logic [UIDX_W-1:0]     i_unit_index,
    input  logic [STAT_W-1:0]     i_unit_status,
    input  logic [TIME_W-1:0]     i_reported_off_time,
    input  logic [TIME_W-1:0]     i_current_time,
    // result channel
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output logic [2:0]            o_mode,
    output logic [TIME_W-1:0]     o_final_off_time,
    output logic                  o_prepare_request,
    output logic                  o_execute_request,
    output logic                  o_request_accepted
);

    // the masks have eight bits, so slots past eight can never be present
    localparam int NUM_SLOTS = (MAX_UNITS < MASK_W) ? MAX_UNITS : MASK_W;

    t_dp_cmd dp_cmd;
    t_dp_sts dp_sts;

    // config writes are registered directly, no back-pressure; held off during reset
    assign o_cfg_ready = i_rst_n;

    // controller: accept an item, walk the unit slots, commit, hold the result
    pdss_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_dp_cmd    (dp_cmd),
        .i_dp_sts    (dp_sts)
    );

    // datapath: tables, readiness and latest-time sweep, sequence state
    pdss_dp #(
        .NUM_SLOTS (NUM_SLOTS)
    ) u_dp (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_cfg_valid         (i_cfg_valid),
        .i_cfg_index         (i_cfg_index),
        .i_cfg_data          (i_cfg_data),
        .i_cmd               (i_cmd),
        .i_unit_index        (i_unit_index),
        .i_unit_status       (i_unit_status),
        .i_reported_off_time (i_reported_off_time),
        .i_current_time      (i_current_time),
        .i_dp_cmd            (dp_cmd),
        .o_dp_sts            (dp_sts),
        .o_mode              (o_mode),
        .o_final_off_time    (o_final_off_time),
        .o_prepare_request   (o_prepare_request),
        .o_execute_request   (o_execute_request),
        .o_request_accepted  (o_request_accepted)
    );

endmodule

>>> hdl/pdss_chk.sv
// port-level checker for the power-down sequence supervisor, with its bind
`include "power_down_sequence_supervisor_top_defines.svh"

module pdss_chk import pdss_pkg::*; (
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  o_in_ready,
    input logic                  o_out_valid,
    input logic                  i_out_ready,
    input logic [2:0]            o_mode,
    input logic                  o_prepare_request,
    input logic                  o_execute_request,
    input logic                  o_request_accepted
);

    `PDSS_ASSERT_NEXT(a_out_hold, o_out_valid && !i_out_ready, o_out_valid, "result dropped")

    `PDSS_ASSERT_NOW(a_one_item, o_out_valid, !o_in_ready, "item taken while result waits")

    `PDSS_ASSERT_NOW(a_prep_mode, o_out_valid && o_prepare_request,
        o_mode == MODE_PREPARING && o_request_accepted, "prepare without preparing mode")

    `PDSS_ASSERT_NOW(a_exec_mode, o_out_valid && o_execute_request,
        o_mode == MODE_READY && !o_prepare_request, "execute outside ready mode")

endmodule

bind power_down_sequence_supervisor_top pdss_chk u_pdss_chk (.*);
